// ===== hdl/fsip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsip_pkg: shared types and constants of the integer format printer
// Word layouts, action codes, ASCII constants, the controller/datapath
// command and status bundles, and the powers-of-ten table.
// ----------------------------------------------------------------------------
package fsip_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CHAR_W             = 8;
    localparam int INT_W              = 32;
    localparam int CNT_OUT_W          = 16;
    localparam int DIGITS             = 10;
    localparam int TABLE_W            = 36;

    // action codes of an input word
    localparam logic [1:0] ACT_FMT = 2'd0;
    localparam logic [1:0] ACT_INT = 2'd1;
    localparam logic [1:0] ACT_STR = 2'd2;
    localparam logic [1:0] ACT_END = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CHAR_S     = 8'h73;

    // position of the most significant decimal digit of a 32-bit magnitude
    localparam logic [3:0] TOP_DIGIT = 4'd9;

    localparam logic [TABLE_W-1:0] POW10 [DIGITS] = '{
        36'd1,
        36'd10,
        36'd100,
        36'd1000,
        36'd10000,
        36'd100000,
        36'd1000000,
        36'd10000000,
        36'd100000000,
        36'd1000000000
    };

    typedef struct packed {
        logic [1:0]              action;
        logic [CHAR_W-1:0]       char_in;
        logic signed [INT_W-1:0] int_value;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    out_char;
        logic                 last;
        logic [CNT_OUT_W-1:0] char_count;
    } out_word_t;

    typedef enum logic [1:0] {
        EMIT_NONE  = 2'd0,
        EMIT_CHAR  = 2'd1,
        EMIT_SIGN  = 2'd2,
        EMIT_DIGIT = 2'd3
    } emit_sel_t;

    typedef struct packed {
        emit_sel_t emit_sel;
        logic      last;
        logic      load_int;
        logic      step;
        logic      clear_count;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic negative;
        logic digit_show;
        logic digit_final;
    } dp_status_t;

endpackage

// ===== hdl/fsip_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsip_stream_if: valid/ready stream channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface fsip_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fsip_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsip_datapath: digit extraction, character counter and output register
// Peels one decimal digit per step off the magnitude, most significant first.
// ----------------------------------------------------------------------------
module fsip_datapath #(
    parameter int COUNT_BITS = fsip_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fsip_pkg::CHAR_W-1:0]   char_in,
    input  logic signed [fsip_pkg::INT_W-1:0] int_value,
    input  fsip_pkg::dp_cmd_t             cmd,
    output fsip_pkg::dp_status_t          status,
    output logic                          out_valid,
    output fsip_pkg::out_word_t           out_word,
    input  logic                          out_ready
);

    logic [fsip_pkg::INT_W-1:0]   rem_reg, rem_next;
    logic [3:0]                   k_reg, k_next;
    logic                         started_reg, started_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next, count_inc;
    logic                         out_valid_reg, out_valid_next;
    fsip_pkg::out_word_t          out_word_reg, out_word_next;

    logic [fsip_pkg::INT_W-1:0]   magnitude;
    logic [fsip_pkg::TABLE_W-1:0] thr [fsip_pkg::DIGITS];
    logic [fsip_pkg::TABLE_W-1:0] rem_wide;
    logic [3:0]                   digit;
    logic [31:0]                  count_wide;
    logic [fsip_pkg::CHAR_W-1:0]  char_sel;
    logic                         slot_free;

    assign magnitude = int_value[fsip_pkg::INT_W-1]
                     ? (fsip_pkg::INT_W'(0) - fsip_pkg::INT_W'(int_value))
                     : fsip_pkg::INT_W'(int_value);
    assign rem_wide  = fsip_pkg::TABLE_W'(rem_reg);

    // multiples of the current power of ten; the digit is how many fit
    always_comb
    begin
        digit  = 4'd0;
        thr[0] = '0;
        for (int m = 1; m < fsip_pkg::DIGITS; m++)
        begin
            thr[m] = fsip_pkg::POW10[k_reg] * fsip_pkg::TABLE_W'(m);
        end
        for (int m = 1; m < fsip_pkg::DIGITS; m++)
        begin
            if (rem_wide >= thr[m])
            begin
                digit = 4'(m);
            end
        end
    end

    assign slot_free  = !out_valid_reg || out_ready;
    assign count_inc  = count_reg + COUNT_BITS'(1);
    assign count_wide = 32'(count_inc);

    assign status.slot_free   = slot_free;
    assign status.negative    = int_value[fsip_pkg::INT_W-1];
    assign status.digit_show  = (digit != 4'd0) || started_reg || (k_reg == 4'd0);
    assign status.digit_final = (k_reg == 4'd0);

    always_comb
    begin
        case (cmd.emit_sel)
            fsip_pkg::EMIT_CHAR:  char_sel = char_in;
            fsip_pkg::EMIT_SIGN:  char_sel = fsip_pkg::CHAR_MINUS;
            fsip_pkg::EMIT_DIGIT: char_sel = fsip_pkg::CHAR_ZERO
                                           + fsip_pkg::CHAR_W'(digit);
            default:              char_sel = fsip_pkg::CHAR_NUL;
        endcase
    end

    always_comb
    begin
        rem_next       = rem_reg;
        k_next         = k_reg;
        started_next   = started_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (cmd.load_int)
        begin
            rem_next     = magnitude;
            k_next       = fsip_pkg::TOP_DIGIT;
            started_next = 1'b0;
        end
        else if (cmd.step)
        begin
            rem_next = rem_reg - thr[digit][fsip_pkg::INT_W-1:0];
            k_next   = k_reg - 4'd1;
            if (cmd.emit_sel == fsip_pkg::EMIT_DIGIT)
            begin
                started_next = 1'b1;
            end
        end

        if (cmd.clear_count)
        begin
            count_next = '0;
        end

        if (cmd.emit_sel != fsip_pkg::EMIT_NONE)
        begin
            count_next               = count_inc;
            out_valid_next           = 1'b1;
            out_word_next.out_char   = char_sel;
            out_word_next.last       = cmd.last;
            out_word_next.char_count = count_wide[fsip_pkg::CNT_OUT_W-1:0];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            started_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            started_reg   <= started_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== hdl/fsip_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsip_ctrl: format parser and conversion sequencer
// Tracks the format mode and steps the datapath through a decimal conversion.
// ----------------------------------------------------------------------------
module fsip_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [fsip_pkg::CHAR_W-1:0] char_in,
    input  fsip_pkg::dp_status_t        status,
    output fsip_pkg::dp_cmd_t           cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DIGIT = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_PCT    = 2'd1,
        MODE_INT    = 2'd2,
        MODE_STR    = 2'd3
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && status.slot_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        fsip_pkg::ACT_FMT:
                        begin
                            if (mode_reg == MODE_PCT)
                            begin
                                mode_next = MODE_NORMAL;
                                if (char_in == fsip_pkg::CHAR_PCT)
                                begin
                                    cmd.emit_sel = fsip_pkg::EMIT_CHAR;
                                    cmd.last     = 1'b1;
                                end
                                else if (char_in == fsip_pkg::CHAR_D)
                                begin
                                    mode_next = MODE_INT;
                                end
                                else if (char_in == fsip_pkg::CHAR_S)
                                begin
                                    mode_next = MODE_STR;
                                end
                            end
                            else if (char_in == fsip_pkg::CHAR_PCT)
                            begin
                                mode_next = MODE_PCT;
                            end
                            else
                            begin
                                // drop any pending argument, pass the char
                                mode_next    = MODE_NORMAL;
                                cmd.emit_sel = fsip_pkg::EMIT_CHAR;
                                cmd.last     = 1'b1;
                            end
                        end
                        fsip_pkg::ACT_INT:
                        begin
                            if (mode_reg == MODE_INT)
                            begin
                                mode_next    = MODE_NORMAL;
                                cmd.load_int = 1'b1;
                                state_next   = ST_DIGIT;
                                if (status.negative)
                                begin
                                    cmd.emit_sel = fsip_pkg::EMIT_SIGN;
                                end
                            end
                        end
                        fsip_pkg::ACT_STR:
                        begin
                            if (mode_reg == MODE_STR)
                            begin
                                if (char_in == fsip_pkg::CHAR_NUL)
                                begin
                                    mode_next = MODE_NORMAL;
                                end
                                else
                                begin
                                    cmd.emit_sel = fsip_pkg::EMIT_CHAR;
                                    cmd.last     = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            mode_next       = MODE_NORMAL;
                            cmd.clear_count = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIGIT:
            begin
                if (!status.digit_show)
                begin
                    // leading zero: advance without output
                    cmd.step = 1'b1;
                end
                else if (status.slot_free)
                begin
                    cmd.step     = 1'b1;
                    cmd.emit_sel = fsip_pkg::EMIT_DIGIT;
                    cmd.last     = status.digit_final;
                    if (status.digit_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_NORMAL;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// ===== hdl/format_string_integer_printer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_string_integer_printer: printf subset formatter (%%, %d, %s)
// Turns a stream of format, argument and end words into ASCII characters,
// each tagged with a running character count.
// ----------------------------------------------------------------------------
//
// channel | dir | payload                           | handshake
// --------+-----+-----------------------------------+-------------
// cmd     | in  | action, char_in, int_value        | valid/ready
// text    | out | out_char, last, char_count        | valid/ready
//
// A format or string word yields at most one character.
// An integer word is loaded, then converted by the extraction loop at one
// digit per cycle unless stalled; the sign goes out in the load cycle and
// leading zeros are skipped without output.
// A stalled text channel holds the output register; the digit loop keeps
// skipping leading zeros but waits at the next digit it has to print.
// cmd is taken only when the sequencer is idle and the output register is
// empty or draining. Reset clears the mode, the count and the output valid.
// ----------------------------------------------------------------------------
module format_string_integer_printer #(
    parameter int COUNT_BITS = fsip_pkg::COUNT_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    fsip_stream_if.sink   cmd,
    fsip_stream_if.source text
);

    fsip_pkg::dp_cmd_t    dp_cmd;
    fsip_pkg::dp_status_t dp_status;
    fsip_pkg::in_word_t   cmd_word;
    fsip_pkg::out_word_t  text_word;

    assign cmd_word = cmd.data;

    // Parser and sequencer: owns the format mode and the conversion state.
    fsip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .action   (cmd_word.action),
        .char_in  (cmd_word.char_in),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // Datapath: magnitude register, digit peel-off, counter, output word.
    fsip_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (cmd_word.char_in),
        .int_value (cmd_word.int_value),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .out_valid (text.valid),
        .out_word  (text_word),
        .out_ready (text.ready)
    );

    assign text.data = text_word;

    // Take a word only when its first character has somewhere to go.
    a_accept_has_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> (!text.valid || text.ready)
    ) else $error("input word taken while output register is blocked");

    // A pending non-final character means a conversion is still running.
    a_no_accept_mid_number: assert property (
        @(posedge clk) disable iff (!rst_n)
        (text.valid && !text_word.last) |-> !cmd.ready
    ) else $error("input ready while a number is still being printed");

    // A loaded conversion never leaves the input open on the next cycle.
    a_int_locks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        dp_cmd.load_int |=> !cmd.ready
    ) else $error("input ready right after an integer load");

endmodule
